// ----- rtl/core/kms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants of the keypad matrix scanner
// Key code table, register indexes, widths and the push request type.
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 5;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned LINES_W = 4;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_WAIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_POLL_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_KEY_EN   = 2'd2;

    localparam logic [7:0] RST_CONFIRM_WAIT   = 8'd1;
    localparam logic [7:0] RST_HOLD_POLL_WAIT = 8'd2;
    localparam logic       RST_POWER_KEY_EN   = 1'b1;

    localparam logic [CODE_W-1:0] POWER_CODE   = 8'h77;
    localparam logic [CODE_W-1:0] RELEASE_CODE = 8'h00;
    localparam logic [CODE_W-1:0] HI_MASK      = 8'hf0;
    localparam logic [CODE_W-1:0] LO_MASK      = 8'h0f;

    localparam logic [CODE_W-1:0] ROW_TAB [4] = '{8'hbe, 8'hdd, 8'h7b, 8'he7};

    // push request from the scanner into the key queue
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } kms_push_t;

    function automatic logic [CODE_W-1:0] kms_key_code(input logic [1:0] row,
                                                      input logic [1:0] col);
        kms_key_code = (ROW_TAB[row] & HI_MASK) | (ROW_TAB[col] & LO_MASK);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/kms_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_if: request channels of the keypad matrix scanner
// Input channel (mode, column sample) and result channel (drive, code, status).
// ----------------------------------------------------------------------------
interface kms_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] col_lines;

    modport source (output valid, output mode, output col_lines, input ready);
    modport sink   (input valid, input mode, input col_lines, output ready);
endinterface

interface kms_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_drive;
    logic [7:0] key_code;
    logic       key_empty;
    logic [2:0] queue_count;

    modport source (output valid, output row_drive, output key_code,
                    output key_empty, output queue_count, input ready);
    modport sink   (input valid, input row_drive, input key_code,
                    input key_empty, input queue_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/kms_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_ctrl: scan sequencer
// Edge detect, row scan with power key check, confirm and hold-poll waits.
// ----------------------------------------------------------------------------
module kms_ctrl
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [kms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kms_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           tick,
    input  wire logic [kms_pkg::LINES_W-1:0]    cols,
    output kms_pkg::kms_push_t                  push,
    output logic [kms_pkg::LINES_W-1:0]         drive_next
);
    import kms_pkg::*;

    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_SCAN         = 3'd1;
    localparam logic [2:0] PH_WAIT_CONFIRM = 3'd2;
    localparam logic [2:0] PH_WAIT_HOLD    = 3'd3;
    localparam logic [2:0] PH_SCAN_HOLD    = 3'd4;

    logic [7:0]         confirm_wait_reg;
    logic [7:0]         hold_poll_wait_reg;
    logic               power_en_reg;

    logic [2:0]         phase_reg, phase_next;
    logic [1:0]         row_reg, row_next;
    logic               power_step_reg, power_step_next;
    logic               pass_reg, pass_next;
    logic [CODE_W-1:0]  first_code_reg, first_code_next;
    logic [7:0]         wait_reg, wait_next;
    logic [LINES_W-1:0] prev_cols_reg, prev_cols_next;

    logic               col_hit;
    logic [1:0]         col_idx;
    logic               scan_done;
    logic               scan_found;
    logic [CODE_W-1:0]  scan_code;
    logic               code_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_wait_reg   <= RST_CONFIRM_WAIT;
            hold_poll_wait_reg <= RST_HOLD_POLL_WAIT;
            power_en_reg       <= RST_POWER_KEY_EN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONFIRM_WAIT:   confirm_wait_reg   <= cfg_data;
                CFG_HOLD_POLL_WAIT: hold_poll_wait_reg <= cfg_data;
                CFG_POWER_KEY_EN:   power_en_reg       <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // lowest column reading low
    always_comb
    begin
        col_hit = 1'b1;
        col_idx = 2'd0;
        priority if (!cols[0]) col_idx = 2'd0;
        else if (!cols[1])     col_idx = 2'd1;
        else if (!cols[2])     col_idx = 2'd2;
        else if (!cols[3])     col_idx = 2'd3;
        else                   col_hit = 1'b0;
    end

    always_comb
    begin
        scan_done  = 1'b0;
        scan_found = 1'b0;
        scan_code  = POWER_CODE;
        if (power_step_reg)
        begin
            if (!cols[3])
            begin
                scan_done  = 1'b1;
                scan_found = 1'b1;
            end
        end
        else if (col_hit)
        begin
            scan_done  = 1'b1;
            scan_found = 1'b1;
            scan_code  = kms_key_code(row_reg, col_idx);
        end
        else if (row_reg == 2'd3)
        begin
            scan_done = 1'b1;
        end
    end

    assign code_match = scan_found && (scan_code == first_code_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        row_next        = row_reg;
        power_step_next = power_step_reg;
        pass_next       = pass_reg;
        first_code_next = first_code_reg;
        wait_next       = wait_reg;
        prev_cols_next  = prev_cols_reg;
        push.valid      = 1'b0;
        push.code       = first_code_reg;

        if (tick)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    // falling edge on any column starts the first pass
                    if ((prev_cols_reg & ~cols) != '0)
                    begin
                        pass_next       = 1'b0;
                        phase_next      = PH_SCAN;
                        row_next        = 2'd0;
                        power_step_next = power_en_reg;
                    end
                    prev_cols_next = cols;
                end
                PH_SCAN, PH_SCAN_HOLD:
                begin
                    if (scan_done)
                    begin
                        power_step_next = 1'b0;
                        row_next        = 2'd0;
                        if (phase_reg == PH_SCAN && !pass_reg)
                        begin
                            if (scan_found)
                            begin
                                first_code_next = scan_code;
                                pass_next       = 1'b1;
                                wait_next       = confirm_wait_reg;
                                phase_next      = PH_WAIT_CONFIRM;
                            end
                            else
                            begin
                                phase_next     = PH_IDLE;
                                pass_next      = 1'b0;
                                prev_cols_next = '0;
                            end
                        end
                        else if (code_match)
                        begin
                            push.valid = (phase_reg == PH_SCAN);
                            wait_next  = hold_poll_wait_reg;
                            phase_next = PH_WAIT_HOLD;
                        end
                        else
                        begin
                            // key gone or changed while held: queue a release
                            push.valid     = (phase_reg == PH_SCAN_HOLD);
                            push.code      = RELEASE_CODE;
                            phase_next     = PH_IDLE;
                            pass_next      = 1'b0;
                            prev_cols_next = '0;
                        end
                    end
                    else if (power_step_reg)
                    begin
                        power_step_next = 1'b0;
                    end
                    else
                    begin
                        row_next        = row_reg + 2'd1;
                        power_step_next = power_en_reg;
                    end
                end
                PH_WAIT_CONFIRM, PH_WAIT_HOLD:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 8'd1;
                    end
                    else
                    begin
                        phase_next      = (phase_reg == PH_WAIT_CONFIRM) ? PH_SCAN
                                                                         : PH_SCAN_HOLD;
                        row_next        = 2'd0;
                        power_step_next = power_en_reg;
                    end
                end
                default:
                begin
                    phase_next     = PH_IDLE;
                    pass_next      = 1'b0;
                    prev_cols_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (phase_next == PH_SCAN || phase_next == PH_SCAN_HOLD)
        begin
            if (power_step_next)
                drive_next = '1;
            else
                drive_next = ~(LINES_W'(1) << row_next);
        end
        else
        begin
            drive_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            row_reg        <= '0;
            power_step_reg <= 1'b0;
            pass_reg       <= 1'b0;
            first_code_reg <= '0;
            wait_reg       <= '0;
            prev_cols_reg  <= '1;
        end
        else
        begin
            phase_reg      <= phase_next;
            row_reg        <= row_next;
            power_step_reg <= power_step_next;
            pass_reg       <= pass_next;
            first_code_reg <= first_code_next;
            wait_reg       <= wait_next;
            prev_cols_reg  <= prev_cols_next;
        end
    end

    a_confirm_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT_CONFIRM) |-> pass_reg)
        else $error("confirm wait without a first pass");

    a_no_power_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_WAIT_CONFIRM ||
         phase_reg == PH_WAIT_HOLD) |-> !power_step_reg)
        else $error("power check pending outside a scan");

    a_push_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (tick && scan_done))
        else $error("push request without a finished scan");

endmodule
`default_nettype wire

// ----- rtl/core/kms_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_queue: key code queue
// Shift queue, oldest entry at the head; pushes into a full queue are dropped.
// ----------------------------------------------------------------------------
module kms_queue
#(
    parameter int unsigned QUEUE_DEPTH = kms_pkg::DEF_QUEUE_DEPTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kms_pkg::kms_push_t           push,
    input  wire logic                        pop,
    output logic [kms_pkg::CODE_W-1:0]       head,
    output logic                             empty,
    output logic [kms_pkg::COUNT_W-1:0]      count_next
);
    import kms_pkg::*;

    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [CODE_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              full;
    logic              do_push;
    logic              do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[0];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_pop)
            fill_next = fill_reg - FILL_W'(1);
        else if (do_push)
            fill_next = fill_reg + FILL_W'(1);
    end

    assign count_next = COUNT_W'(fill_next);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (do_pop)
            begin
                if (i < QUEUE_DEPTH - 1)
                    entry_reg[i] <= entry_reg[(i + 1) % QUEUE_DEPTH];
            end
            else if (do_push && fill_reg == FILL_W'(i))
            begin
                entry_reg[i] <= push.code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop && full) |=> full)
        else $error("push into full queue changed the fill");

    a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && empty && !push.valid) |=> empty)
        else $error("pop on empty queue changed the fill");

endmodule
`default_nettype wire

// ----- rtl/core/keypad_matrix_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_matrix_scanner: 4x4 key matrix scanner with debounce and key queue
// Top level: input register, scan sequencer, key queue and result register.
// ----------------------------------------------------------------------------
// One request is taken every clock while the input does not stall. Each
// request (a scan tick with a column sample, or a pop) lands in an input
// register, is handled in a single pass of the scan sequencer or the key
// queue and comes out of the result register, where it is held until the
// sink takes it. The input register doubles as a skid stage: one more
// request is taken while a result waits for its sink, then the input stalls
// until the result goes.
// Drive the rows with row_drive of the last result and sample the columns
// before the next scan tick. Write the configuration registers only while no
// request is in flight.
module keypad_matrix_scanner
#(
    parameter int unsigned QUEUE_DEPTH = kms_pkg::DEF_QUEUE_DEPTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    kms_in_if.sink                              key_in,
    kms_out_if.source                           key_out,
    input  wire logic                           cfg_we,
    input  wire logic [kms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kms_pkg::*;

    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [LINES_W-1:0] in_cols_reg;
    logic               advance;

    logic               out_valid_reg;
    logic [LINES_W-1:0] out_drive_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_empty_reg;
    logic [COUNT_W-1:0] out_count_reg;

    kms_push_t          push;
    logic [LINES_W-1:0] drive_next;
    logic [CODE_W-1:0]  q_head;
    logic               q_empty;
    logic [COUNT_W-1:0] q_count_next;
    logic               tick;
    logic               pop;

    assign advance      = in_valid_reg && (!out_valid_reg || key_out.ready);
    assign key_in.ready = !in_valid_reg || advance;
    assign tick         = advance && !in_mode_reg;
    assign pop          = advance && in_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (key_in.ready)
            in_valid_reg <= key_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (key_in.ready && key_in.valid)
        begin
            in_mode_reg <= key_in.mode;
            in_cols_reg <= key_in.col_lines;
        end
    end

    kms_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick       (tick),
        .cols       (in_cols_reg),
        .push       (push),
        .drive_next (drive_next)
    );

    kms_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (q_head),
        .empty      (q_empty),
        .count_next (q_count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (key_out.ready)
            out_valid_reg <= 1'b0;
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_drive_reg <= drive_next;
            out_code_reg  <= (pop && !q_empty) ? q_head : RELEASE_CODE;
            out_empty_reg <= pop && q_empty;
            out_count_reg <= q_count_next;
        end
    end

    assign key_out.valid       = out_valid_reg;
    assign key_out.row_drive   = out_drive_reg;
    assign key_out.key_code    = out_code_reg;
    assign key_out.key_empty   = out_empty_reg;
    assign key_out.queue_count = out_count_reg;

endmodule
`default_nettype wire
